// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion helpers, clocked on clk, disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// ante implies cons at the same edge
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/nec_ir_pkg.sv -----
`timescale 1ns / 1ps

package nec_ir_pkg;

	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REG_LEADER = 2'd0,
		REG_SHORT  = 2'd1,
		REG_LONG   = 2'd2
	} reg_idx_t;

	localparam int unsigned CODE_W = 16;
	localparam int unsigned RELOAD_W = 16;
	localparam int unsigned STEP_W = 7;

	localparam logic [RELOAD_W-1:0] LEADER_RELOAD_RST = 16'hD300;
	localparam logic [RELOAD_W-1:0] SHORT_RELOAD_RST  = 16'h19FF;
	localparam logic [RELOAD_W-1:0] LONG_RELOAD_RST   = 16'h4DFF;

	localparam logic [STEP_W-1:0] STEP_LEADER_MARK  = 7'd0;
	localparam logic [STEP_W-1:0] STEP_LEADER_SPACE = 7'd1;
	localparam logic [STEP_W-1:0] STEP_VENDOR_LAST  = 7'd34;
	localparam logic [STEP_W-1:0] STEP_DATA_LAST    = 7'd66;
	localparam logic [STEP_W-1:0] STEP_TAIL_LAST    = 7'd68;
	localparam logic [STEP_W-1:0] STEP_END          = 7'd69;

endpackage

// ----- rtl/core/nec_ir_in_if.sv -----
`timescale 1ns / 1ps

interface nec_ir_in_if;
	import nec_ir_pkg::*;

	logic                valid;
	logic                ready;
	opcode_t             opcode;
	logic [CODE_W-1:0]   vendor_code;
	logic [CODE_W-1:0]   key_code;

	modport source (output valid, output opcode, output vendor_code, output key_code,
		input ready);
	modport sink (input valid, input opcode, input vendor_code, input key_code,
		output ready);
endinterface

// ----- rtl/core/nec_ir_out_if.sv -----
`timescale 1ns / 1ps

interface nec_ir_out_if;
	import nec_ir_pkg::*;

	logic                valid;
	logic                ready;
	logic                ir_level;
	logic [RELOAD_W-1:0] next_reload;
	logic                finished;

	modport source (output valid, output ir_level, output next_reload, output finished,
		input ready);
	modport sink (input valid, input ir_level, input next_reload, input finished,
		output ready);
endinterface

// ----- rtl/core/nec_ir_transmit_sequencer.sv -----
`timescale 1ns / 1ps
// Channel   | Dir | Word
// in_ch     | in  | opcode, vendor_code, key_code
// out_ch    | out | ir_level, next_reload, finished
// cfg_*     | in  | register index, 16-bit reload value
//
// An accepted word passes through the input register, then the result register.
// One word per cycle sustained while out_ch is ready; the input register advances
// whenever the result register is empty or being taken. A tick while idle yields
// no word. Reset clears step state and restores the reload registers to defaults.
`include "assert_macros.svh"

module nec_ir_transmit_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	nec_ir_in_if.sink                     in_ch,
	nec_ir_out_if.source                  out_ch,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_idx,
	input  logic [nec_ir_pkg::RELOAD_W-1:0] cfg_wdata
);
	import nec_ir_pkg::*;

	logic [RELOAD_W-1:0] leader_q, short_q, long_q;

	logic                valid_s1;
	opcode_t             op_s1;
	logic [CODE_W-1:0]   vendor_s1, key_s1;

	logic [STEP_W-1:0]   step_q, step_d;
	logic [CODE_W-1:0]   vendor_q, vendor_d, key_q, key_d;
	logic                level_q, level_d, active_q, active_d;

	logic                res_vld, res_level, res_fin;
	logic [RELOAD_W-1:0] res_reload;

	logic                out_valid_q, out_level_q, out_fin_q;
	logic [RELOAD_W-1:0] out_reload_q;

	logic                out_free, adv;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign adv         = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leader_q <= LEADER_RELOAD_RST;
			short_q  <= SHORT_RELOAD_RST;
			long_q   <= LONG_RELOAD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LEADER: leader_q <= cfg_wdata;
				REG_SHORT:  short_q  <= cfg_wdata;
				REG_LONG:   long_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			op_s1     <= in_ch.opcode;
			vendor_s1 <= in_ch.vendor_code;
			key_s1    <= in_ch.key_code;
		end
	end

	always_comb begin
		step_d     = step_q;
		vendor_d   = vendor_q;
		key_d      = key_q;
		level_d    = level_q;
		active_d   = active_q;
		res_vld    = 1'b0;
		res_reload = '0;
		res_fin    = 1'b0;
		if (op_s1 == OP_START) begin
			vendor_d   = vendor_s1;
			key_d      = key_s1;
			level_d    = 1'b1;
			step_d     = '0;
			active_d   = 1'b1;
			res_vld    = 1'b1;
			res_reload = leader_q;
		end else if (active_q) begin
			res_vld = 1'b1;
			step_d  = step_q + 1'b1;
			if (step_q == STEP_LEADER_MARK) begin
				res_reload = leader_q;
			end else if (step_q == STEP_LEADER_SPACE) begin
				level_d    = !level_q;
				res_reload = leader_q;
			end else if (step_q <= STEP_DATA_LAST) begin
				level_d    = !level_q;
				res_reload = short_q;
				if (step_q[0]) begin
					if (step_q <= STEP_VENDOR_LAST) begin
						if (vendor_q[CODE_W-1]) res_reload = long_q;
						vendor_d = {vendor_q[CODE_W-2:0], 1'b0};
					end else begin
						if (key_q[CODE_W-1]) res_reload = long_q;
						key_d = {key_q[CODE_W-2:0], 1'b0};
					end
				end
			end else if (step_q <= STEP_TAIL_LAST) begin
				level_d    = !level_q;
				res_reload = short_q;
			end else begin
				level_d  = 1'b0;
				res_fin  = 1'b1;
				active_d = 1'b0;
				step_d   = step_q;
			end
		end
		res_level = level_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			vendor_q <= '0;
			key_q    <= '0;
			level_q  <= 1'b0;
			active_q <= 1'b0;
		end else if (adv) begin
			step_q   <= step_d;
			vendor_q <= vendor_d;
			key_q    <= key_d;
			level_q  <= level_d;
			active_q <= active_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_level_q  <= res_level;
			out_reload_q <= res_reload;
			out_fin_q    <= res_fin;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.ir_level    = out_level_q;
	assign out_ch.next_reload = out_reload_q;
	assign out_ch.finished    = out_fin_q;

	`ASSERT_ALWAYS(a_step_bound, step_q <= STEP_END, "step count ran past frame end")
	`ASSERT_IMPL(a_fin_word, out_valid_q && out_fin_q,
		!out_level_q && out_reload_q == '0, "finished word not low with zero reload")
	`ASSERT_IMPL(a_idle_on_fin, !active_q && $past(active_q),
		out_valid_q && out_fin_q, "went idle without a finished word")
	`ASSERT_NEXT(a_start_load, adv && op_s1 == OP_START,
		active_q && step_q == STEP_LEADER_MARK && level_q, "start did not arm the frame")
	`ASSERT_IMPL(a_idle_step, active_q && step_q == STEP_END, level_q,
		"level low before final step")

endmodule

// ----- bench/nec_ir_seq_checker.sv -----
`timescale 1ns / 1ps

module nec_ir_seq_checker import nec_ir_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	nec_ir_in_if                in_mon,
	nec_ir_out_if               out_mon,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [RELOAD_W-1:0] cfg_wdata,
	output int                  fails,
	output int                  pending
);

	typedef struct packed {
		logic                ir_level;
		logic [RELOAD_W-1:0] next_reload;
		logic                finished;
	} ir_word_t;

	logic [RELOAD_W-1:0] leader_r;
	logic [RELOAD_W-1:0] short_r;
	logic [RELOAD_W-1:0] long_r;
	logic [STEP_W-1:0]   step;
	logic [CODE_W-1:0]   vendor_sr;
	logic [CODE_W-1:0]   key_sr;
	logic                level;
	logic                busy;
	int                  err_cnt;
	ir_word_t            frame_q[$];

	// advances the frame state by one word; returns 0 when the word yields nothing
	function automatic bit next_frame_word(input opcode_t op, input logic [CODE_W-1:0] vc,
		input logic [CODE_W-1:0] kc, output ir_word_t w);
		logic [RELOAD_W-1:0] rl;
		logic                fin;
		w = '0;
		fin = 1'b0;
		if (op == OP_START) begin
			vendor_sr = vc;
			key_sr = kc;
			level = 1'b1;
			step = '0;
			busy = 1'b1;
			w.ir_level = 1'b1;
			w.next_reload = leader_r;
			return 1'b1;
		end
		if (!busy)
			return 1'b0;
		if (step == STEP_LEADER_MARK) begin
			rl = leader_r;
		end else if (step == STEP_LEADER_SPACE) begin
			level = ~level;
			rl = leader_r;
		end else if (step <= STEP_DATA_LAST) begin
			level = ~level;
			rl = short_r;
			if (step[0]) begin
				if (step <= STEP_VENDOR_LAST) begin
					if (vendor_sr[CODE_W-1])
						rl = long_r;
					vendor_sr = vendor_sr << 1;
				end else begin
					if (key_sr[CODE_W-1])
						rl = long_r;
					key_sr = key_sr << 1;
				end
			end
		end else if (step <= STEP_TAIL_LAST) begin
			level = ~level;
			rl = short_r;
		end else begin
			level = 1'b0;
			rl = '0;
			fin = 1'b1;
			busy = 1'b0;
		end
		if (!fin)
			step = step + 1'b1;
		w.ir_level = level;
		w.next_reload = rl;
		w.finished = fin;
		return 1'b1;
	endfunction

	function automatic void note_mismatch(input string what, input ir_word_t want,
		input ir_word_t got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t %s: exp level %0b reload %h fin %0b, got level %0b reload %h fin %0b",
				$realtime, what, want.ir_level, want.next_reload, want.finished,
				got.ir_level, got.next_reload, got.finished);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ir_word_t want;
		ir_word_t got;
		if (!arst_n) begin
			leader_r = LEADER_RELOAD_RST;
			short_r = SHORT_RELOAD_RST;
			long_r = LONG_RELOAD_RST;
			step = '0;
			vendor_sr = '0;
			key_sr = '0;
			level = 1'b0;
			busy = 1'b0;
			err_cnt = 0;
			frame_q.delete();
			fails <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_LEADER: leader_r = cfg_wdata;
					REG_SHORT:  short_r = cfg_wdata;
					REG_LONG:   long_r = cfg_wdata;
					default:    ;
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				got.ir_level = out_mon.ir_level;
				got.next_reload = out_mon.next_reload;
				got.finished = out_mon.finished;
				if (frame_q.size() == 0) begin
					note_mismatch("unexpected word", '0, got);
				end else begin
					want = frame_q.pop_front();
					if (got.ir_level !== want.ir_level || got.next_reload !== want.next_reload
						|| got.finished !== want.finished)
						note_mismatch("mismatch", want, got);
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				if (next_frame_word(in_mon.opcode, in_mon.vendor_code, in_mon.key_code, want))
					frame_q.push_back(want);
			end
			pending <= frame_q.size();
			fails <= err_cnt;
		end
	end

endmodule

// ----- bench/nec_ir_transmit_sequencer_tb.sv -----
`timescale 1ns / 1ps

module nec_ir_transmit_sequencer_tb;
	import nec_ir_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int FRAME_TICKS = 70;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_WORDS = 125;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we;
	logic [1:0]          cfg_idx;
	logic [RELOAD_W-1:0] cfg_wdata;
	int                  tx_idle_pct = 0;
	int                  rx_idle_pct = 0;
	int                  fails;
	int                  pending;

	nec_ir_in_if  in_ch ();
	nec_ir_out_if out_ch ();

	nec_ir_transmit_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	nec_ir_seq_checker mon (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_mon    (in_ch),
		.out_mon   (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.fails     (fails),
		.pending   (pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic send_word(input opcode_t op, input logic [CODE_W-1:0] vc,
		input logic [CODE_W-1:0] kc);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.vendor_code <= vc;
		in_ch.key_code <= kc;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// hold off until every expected word is back, then let the pipe settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [RELOAD_W-1:0] ld, input logic [RELOAD_W-1:0] sh,
		input logic [RELOAD_W-1:0] lg);
		cfg_we <= 1'b1;
		cfg_idx <= REG_LEADER;
		cfg_wdata <= ld;
		@(posedge clk);
		cfg_idx <= REG_SHORT;
		cfg_wdata <= sh;
		@(posedge clk);
		cfg_idx <= REG_LONG;
		cfg_wdata <= lg;
		@(posedge clk);
		cfg_idx <= REG_SPARE;
		cfg_wdata <= RELOAD_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CODE_W-1:0] pick_code();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return CODE_W'($urandom);
		endcase
	endfunction

	// mostly whole frames; some cut short and restarted by the next start
	task automatic run_frames(input int quota);
		int n;
		int ticks;
		n = 0;
		while (n < quota) begin
			send_word(OP_START, pick_code(), pick_code());
			n++;
			if ($urandom_range(4) == 0)
				ticks = $urandom_range(1, FRAME_TICKS - 1);
			else
				ticks = FRAME_TICKS;
			repeat (ticks) send_word(OP_TICK, CODE_W'($urandom), CODE_W'($urandom));
			n += ticks;
			if (ticks == FRAME_TICKS)
				repeat ($urandom_range(2))
					send_word(OP_TICK, CODE_W'($urandom), CODE_W'($urandom));
			if ($urandom_range(3) == 0)
				drain();
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_TICK;
		in_ch.vendor_code = '0;
		in_ch.key_code = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_LEADER;
		cfg_wdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default reloads: idle tick, start, restart mid-frame
		send_word(OP_TICK, '1, '1);
		send_word(OP_START, 16'hFFFF, 16'h0000);
		repeat (8) send_word(OP_TICK, '0, '0);
		send_word(OP_START, 16'h0000, 16'hFFFF);
		repeat (8) send_word(OP_TICK, '1, '0);
		drain();

		program_regs(16'hFFFF, 16'h0000, 16'hFFFF);
		tx_idle_pct = 19;
		rx_idle_pct = 64;
		run_frames(PHASE_WORDS);
		drain();

		program_regs(16'h0000, 16'hFFFF, 16'h0000);
		tx_idle_pct = 64;
		rx_idle_pct = 19;
		run_frames(PHASE_WORDS);
		drain();

		program_regs(RELOAD_W'($urandom), RELOAD_W'($urandom), RELOAD_W'($urandom));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_frames(PHASE_WORDS);
		drain();

		if (fails == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
